>>> rtl/core/nfa_pkg.sv
// ----------------------------------------------------------------------------
// NFA state set step package
// Shared types and constants for the NFA edge-table stepping engine.
// ----------------------------------------------------------------------------
`default_nettype none

package nfa_pkg;

    // Default sizing of the automaton.
    localparam int DEF_STATE_COUNT = 32;
    localparam int DEF_EDGE_SLOTS  = 128;

    // Fixed field widths of the stream words.
    localparam int SLOT_W   = 7;
    localparam int STATE_W  = 5;
    localparam int BYTE_W   = 8;
    localparam int MASK_W   = 32;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 32;

    // Slot indexes reachable through the input word.
    localparam int SLOT_SPACE = 1 << SLOT_W;

    // Operation selected by an input word.
    typedef enum logic [1:0] {
        ACT_WRITE_SLOT = 2'd0,
        ACT_LOAD_SET   = 2'd1,
        ACT_STEP_BYTE  = 2'd2,
        ACT_STEP_RANGE = 2'd3
    } t_action;

    // Controller states, one-hot.
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    // Stored part of one edge slot; the valid bit lives in flip-flops.
    typedef struct packed {
        logic [STATE_W-1:0] src;
        logic [STATE_W-1:0] dst;
        logic [BYTE_W-1:0]  lo;
        logic [BYTE_W-1:0]  hi;
    } t_edge;

endpackage

`default_nettype wire

>>> rtl/core/nfa_state_set_step_top.sv
// ----------------------------------------------------------------------------
// NFA state set step
// Edge-table NFA engine: writes edge slots, loads or steps the active set.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on the s_axis group. tuser carries the operation
//   (write slot, load set, step by byte, step by exact range); tdata carries
//   the slot, edge and mask fields. Every accepted word answers with exactly
//   one output word on the m_axis group: tdata is the active state set after
//   the operation and tuser is set when that set is empty.
//   A slot write or set load goes straight to the done state, without a
//   scan. A step reads the edge memory one slot per cycle through its
//   single read port, over all min(EDGE_SLOTS, 128) table slots, then
//   commits the new set in a drain state. One word is processed at a time.
//   The output word sits in its own register, so a new input word is taken
//   while an earlier result still waits; a stalled receiver only holds the
//   engine once the next result is ready to be written.
//   Reset marks all slots invalid and clears the active set; no clearing
//   pass over the memory is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module nfa_state_set_step_top
    import nfa_pkg::*;
#(
    parameter int STATE_COUNT = DEF_STATE_COUNT,
    parameter int EDGE_SLOTS  = DEF_EDGE_SLOTS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Input stream.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata: slot[6:0], slot_valid[7], source_state[12:8], dest_state[17:13],
    //        range_low[25:18], range_high[33:26], active_mask[65:34],
    //        symbol[73:66], zero fill [79:74]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: action[1:0]
    input  wire logic [1:0]            s_axis_tuser,
    // Output stream.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // tdata: current_states[31:0]
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // tuser: none_reached[0]
    output logic                       m_axis_tuser
);

    // Only the first 128 slots can ever be written through the word.
    localparam int TABLE_DEPTH = (EDGE_SLOTS < SLOT_SPACE) ? EDGE_SLOTS : SLOT_SPACE;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int ACT_W       = STATE_COUNT;

    // Unpacked input fields.
    logic [SLOT_W-1:0]  in_slot;
    logic               in_slot_valid;
    logic [STATE_W-1:0] in_src;
    logic [STATE_W-1:0] in_dst;
    logic [BYTE_W-1:0]  in_lo;
    logic [BYTE_W-1:0]  in_hi;
    logic [MASK_W-1:0]  in_mask;
    logic [BYTE_W-1:0]  in_symbol;
    t_action            in_action;

    assign in_slot       = s_axis_tdata[6:0];
    assign in_slot_valid = s_axis_tdata[7];
    assign in_src        = s_axis_tdata[12:8];
    assign in_dst        = s_axis_tdata[17:13];
    assign in_lo         = s_axis_tdata[25:18];
    assign in_hi         = s_axis_tdata[33:26];
    assign in_mask       = s_axis_tdata[65:34];
    assign in_symbol     = s_axis_tdata[73:66];
    assign in_action     = t_action'(s_axis_tuser);

    // Controller and datapath registers.
    t_state               r_state, n_state;
    t_action              r_action;
    logic [BYTE_W-1:0]    r_lo;
    logic [BYTE_W-1:0]    r_hi;
    logic [BYTE_W-1:0]    r_symbol;
    logic [IDX_W-1:0]     r_scan_idx;
    logic                 r_rd_v;
    logic                 r_rd_live;
    t_edge                r_rd_edge;
    logic [ACT_W-1:0]     r_next;
    logic [ACT_W-1:0]     r_active;
    logic [TABLE_DEPTH-1:0] r_live;
    logic                 r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_states;
    logic                 r_out_empty;

    // Edge memory, one synchronous read port and one write port.
    t_edge                edge_mem [TABLE_DEPTH];

    logic                 accept;
    logic                 slot_ok;
    logic                 write_ok;
    logic [ACT_W-1:0]     src_shift;
    logic                 src_active;
    logic                 range_hit;
    logic                 edge_hit;
    logic [ACT_W-1:0]     hit_mask;
    logic [ACT_W-1:0]     scan_result;
    logic [63:0]          mask_wide;
    logic [63:0]          active_wide;
    logic                 out_free;
    logic                 scan_last;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Slot writes outside the table or naming a state beyond the count are dropped.
    assign slot_ok  = (13'(in_slot) < 13'(EDGE_SLOTS));
    assign write_ok = slot_ok && (7'(in_src) < 7'(STATE_COUNT))
                              && (7'(in_dst) < 7'(STATE_COUNT));

    // Match of the slot just read against the step condition.
    assign src_shift  = r_active >> r_rd_edge.src;
    assign src_active = src_shift[0];
    always_comb begin
        if (r_action == ACT_STEP_BYTE) begin
            range_hit = (r_symbol >= r_rd_edge.lo) && (r_symbol <= r_rd_edge.hi);
        end else begin
            range_hit = (r_rd_edge.lo == r_lo) && (r_rd_edge.hi == r_hi);
        end
    end
    assign edge_hit    = r_rd_v && r_rd_live && src_active && range_hit;
    assign hit_mask    = edge_hit ? (ACT_W'(1) << r_rd_edge.dst) : '0;
    assign scan_result = r_next | hit_mask;

    assign mask_wide   = 64'(in_mask);
    assign active_wide = 64'(r_active);
    assign out_free    = !r_out_valid || m_axis_tready;
    assign scan_last   = (r_scan_idx == IDX_W'(TABLE_DEPTH - 1));

    // Next-state logic of the controller.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (in_action == ACT_STEP_BYTE || in_action == ACT_STEP_RANGE) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Edge memory write at acceptance and scan read.
    always_ff @(posedge i_clk) begin
        if (accept && in_action == ACT_WRITE_SLOT && write_ok) begin
            edge_mem[in_slot[IDX_W-1:0]] <= '{src: in_src, dst: in_dst,
                                              lo: in_lo, hi: in_hi};
        end
        r_rd_edge <= edge_mem[r_scan_idx];
    end

    // Control registers, valid bits and the active set.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_v      <= 1'b0;
            r_live      <= '0;
            r_active    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_v    <= (r_state == S_SCAN);
            r_rd_live <= r_live[r_scan_idx];
            if (accept && in_action == ACT_WRITE_SLOT && write_ok) begin
                r_live[in_slot[IDX_W-1:0]] <= in_slot_valid;
            end
            if (accept && in_action == ACT_LOAD_SET) begin
                r_active <= mask_wide[ACT_W-1:0];
            end
            if (r_state == S_DRAIN) begin
                r_active <= scan_result;
            end
            // Output register: load a finished result, drop a taken one.
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Step operands, scan counter and accumulated destination set.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action   <= in_action;
            r_lo       <= in_lo;
            r_hi       <= in_hi;
            r_symbol   <= in_symbol;
            r_scan_idx <= '0;
            r_next     <= '0;
        end else begin
            if (r_state == S_SCAN && !scan_last) begin
                r_scan_idx <= r_scan_idx + IDX_W'(1);
            end
            if (r_rd_v) begin
                r_next <= scan_result;
            end
        end
        if (r_state == S_DONE && out_free) begin
            r_out_states <= active_wide[OUT_DATA_W-1:0];
            r_out_empty  <= (active_wide[OUT_DATA_W-1:0] == '0);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_states;
    assign m_axis_tuser  = r_out_empty;

    // The last read of a scan is always in flight when the result is committed.
    a_drain_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> r_rd_v)
        else $error("scan committed without its last slot read");

    // A slot write or set load completes without a scan.
    a_short_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (in_action == ACT_WRITE_SLOT || in_action == ACT_LOAD_SET))
        |=> (r_state == S_DONE))
        else $error("short operation did not go straight to completion");

    // A step starts from the first slot with an empty destination set.
    a_step_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (in_action == ACT_STEP_BYTE || in_action == ACT_STEP_RANGE))
        |=> (r_scan_idx == '0 && r_next == '0 && r_state == S_SCAN))
        else $error("step did not start from a clean scan");

    // The empty flag agrees with the set it goes out with.
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata == '0)))
        else $error("empty flag does not match the state set");

endmodule

`default_nettype wire
